[src/tar_pkg.sv]
// Package with the shared types and constants of the tar archive stream deframer.
`default_nettype none
package tar_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int SIZE_W      = 36;

  localparam logic [POS_W-1:0] SIZE_FIRST  = POS_W'(124);
  localparam logic [POS_W-1:0] SIZE_LAST   = POS_W'(135);
  localparam logic [POS_W-1:0] TYPE_OFFSET = POS_W'(156);
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(BLOCK_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_PAD    = 2'd2,
    PH_END    = 2'd3
  } phase_t;

  localparam logic [1:0] ROLE_HEADER = 2'd0;
  localparam logic [1:0] ROLE_DATA   = 2'd1;
  localparam logic [1:0] ROLE_PAD    = 2'd2;
  localparam logic [1:0] ROLE_END    = 2'd3;

endpackage
`default_nettype wire

[src/tar_archive_stream_deframer.sv]
// Top level of the tar archive stream deframer.
//
// The block takes a tar archive one byte per input transfer on in_valid and
// in_ready, and gives exactly one result per byte on out_valid and out_ready.
// Each result passes the byte through and labels it as header, file data,
// block padding or past the end of the archive. On the last byte of a header
// the parsed octal size and the type flag are shown with header_done.
// A byte sits in an input register, then the state update and the labeling
// are done together into the result register, which drives out_valid. One
// byte is taken every cycle while the receiver keeps out_ready high; the
// state update feeding the result register directly sets that rate.
// When the receiver stalls, the result is held and the input register
// takes one more byte only if it is empty; in_ready then falls.
// A synchronous reset empties both registers and returns the parser to the
// start of a header block with all counters cleared.
`default_nettype none
module tar_archive_stream_deframer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                archive_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     byte_out,
  output logic [1:0]                     byte_role,
  output logic                           header_start,
  output logic                           header_done,
  output logic [tar_pkg::SIZE_W-1:0]     file_size,
  output logic [7:0]                     entry_type,
  output logic                           last_data
);
  import tar_pkg::*;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              advance;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  block_position, block_position_next;
  logic [SIZE_W-1:0] size_accumulator, size_accumulator_next;
  logic              size_digits_stopped, size_digits_stopped_next;
  logic [SIZE_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [POS_W-1:0]  padding_remaining, padding_remaining_next;
  logic [7:0]        type_capture, type_capture_next;

  logic [1:0]        role_next;
  logic              hstart_next, hdone_next, last_next;
  logic [SIZE_W-1:0] fsize_next;
  logic [7:0]        etype_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_byte <= archive_byte;
    end
  end

  always_comb begin
    phase_next               = phase;
    block_position_next      = block_position;
    size_accumulator_next    = size_accumulator;
    size_digits_stopped_next = size_digits_stopped;
    bytes_remaining_next     = bytes_remaining;
    padding_remaining_next   = padding_remaining;
    type_capture_next        = type_capture;
    role_next                = ROLE_END;
    hstart_next              = 1'b0;
    hdone_next               = 1'b0;
    fsize_next               = '0;
    etype_next               = '0;
    last_next                = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (block_position == '0 && s1_byte == 8'd0) begin
          phase_next = PH_END;
        end else begin
          role_next = ROLE_HEADER;
          if (block_position == '0) begin
            hstart_next              = 1'b1;
            size_accumulator_next    = '0;
            size_digits_stopped_next = 1'b0;
            type_capture_next        = '0;
          end
          if (block_position >= SIZE_FIRST && block_position <= SIZE_LAST &&
              !size_digits_stopped) begin
            if (s1_byte[7:3] == 5'b00110) begin
              size_accumulator_next = {size_accumulator[SIZE_W-4:0], s1_byte[2:0]};
            end else begin
              size_digits_stopped_next = 1'b1;
            end
          end
          if (block_position == TYPE_OFFSET) begin
            type_capture_next = s1_byte;
          end
          if (block_position == LAST_POS) begin
            hdone_next             = 1'b1;
            fsize_next             = size_accumulator;
            etype_next             = type_capture;
            bytes_remaining_next   = size_accumulator;
            padding_remaining_next = POS_W'(0) - size_accumulator[POS_W-1:0];
            block_position_next    = '0;
            phase_next = (size_accumulator != '0) ? PH_DATA : PH_HEADER;
          end else begin
            block_position_next = block_position + POS_W'(1);
          end
        end
      end
      PH_DATA: begin
        role_next = ROLE_DATA;
        if (bytes_remaining != '0) begin
          bytes_remaining_next = bytes_remaining - SIZE_W'(1);
        end
        if (bytes_remaining <= SIZE_W'(1)) begin
          last_next           = 1'b1;
          block_position_next = '0;
          phase_next = (padding_remaining != '0) ? PH_PAD : PH_HEADER;
        end
      end
      PH_PAD: begin
        role_next = ROLE_PAD;
        if (padding_remaining != '0) begin
          padding_remaining_next = padding_remaining - POS_W'(1);
        end
        if (padding_remaining <= POS_W'(1)) begin
          block_position_next = '0;
          phase_next          = PH_HEADER;
        end
      end
      default: begin
        role_next = ROLE_END;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HEADER;
      block_position      <= '0;
      size_accumulator    <= '0;
      size_digits_stopped <= 1'b0;
      bytes_remaining     <= '0;
      padding_remaining   <= '0;
      type_capture        <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (advance) begin
        phase               <= phase_next;
        block_position      <= block_position_next;
        size_accumulator    <= size_accumulator_next;
        size_digits_stopped <= size_digits_stopped_next;
        bytes_remaining     <= bytes_remaining_next;
        padding_remaining   <= padding_remaining_next;
        type_capture        <= type_capture_next;
        out_valid           <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      byte_out     <= s1_byte;
      byte_role    <= role_next;
      header_start <= hstart_next;
      header_done  <= hdone_next;
      file_size    <= fsize_next;
      entry_type   <= etype_next;
      last_data    <= last_next;
    end
  end

endmodule
`default_nettype wire

[src/tar_checker.sv]
// Port-level assertion checker for the tar archive stream deframer and its bind.
`default_nettype none
module tar_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [7:0]                byte_out,
  input wire logic [1:0]                byte_role,
  input wire logic                      header_start,
  input wire logic                      header_done,
  input wire logic [tar_pkg::SIZE_W-1:0] file_size,
  input wire logic [7:0]                entry_type,
  input wire logic                      last_data
);
  import tar_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(byte_role))
    else $error("stalled result changed");

  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && byte_role == ROLE_END |=> !out_valid || byte_role == ROLE_END)
    else $error("result after archive end not labeled as end");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !header_done |-> file_size == '0 && entry_type == '0)
    else $error("size or type shown outside header end");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (header_start || header_done) |->
      byte_role == ROLE_HEADER && !last_data && !(header_start && header_done))
    else $error("header flags on a byte that is not a header byte");

endmodule

bind tar_archive_stream_deframer tar_checker u_tar_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .byte_out     (byte_out),
  .byte_role    (byte_role),
  .header_start (header_start),
  .header_done  (header_done),
  .file_size    (file_size),
  .entry_type   (entry_type),
  .last_data    (last_data)
);
`default_nettype wire
